// ----- rtl/i2a_pkg.sv -----
package i2a_pkg;

  localparam int ValueWidthDefault = 32;
  localparam int RadixW = 6;
  localparam int CharW = 8;
  localparam int PcW = 3;

  localparam logic [RadixW-1:0] RadixReset = 6'd10;
  localparam logic [RadixW-1:0] RadixDecimal = 6'd10;
  localparam logic [RadixW-1:0] RadixMin = 6'd2;
  localparam logic [RadixW-1:0] RadixMax = 6'd36;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharLetterA = 8'h41;

  typedef enum logic [2:0] {
    OpNop,
    OpWait,
    OpDiv,
    OpStore,
    OpSign,
    OpRead,
    OpEmit
  } op_e;

  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondIdle,
    CondDivMore,
    CondMoreDigits,
    CondMoreChars
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic div_more;
    logic more_digits;
    logic more_chars;
  } status_t;

  localparam logic [PcW-1:0] PcIdle = 3'd0;
  localparam logic [PcW-1:0] PcDiv  = 3'd1;
  localparam logic [PcW-1:0] PcRead = 3'd4;

  // microprogram
  function automatic ctrl_t rom_word(input logic [PcW-1:0] pc);
    ctrl_t w;
    case (pc)
      3'd0: w = '{op: OpWait,  cond: CondIdle,       target: PcIdle};
      3'd1: w = '{op: OpDiv,   cond: CondDivMore,    target: PcDiv};
      3'd2: w = '{op: OpStore, cond: CondMoreDigits, target: PcDiv};
      3'd3: w = '{op: OpSign,  cond: CondNever,      target: PcIdle};
      3'd4: w = '{op: OpRead,  cond: CondNever,      target: PcIdle};
      3'd5: w = '{op: OpEmit,  cond: CondMoreChars,  target: PcRead};
      3'd6: w = '{op: OpNop,   cond: CondAlways,     target: PcIdle};
      default: w = '{op: OpNop, cond: CondAlways,    target: PcIdle};
    endcase
    return w;
  endfunction

  function automatic logic [RadixW-1:0] effective_radix(input logic [RadixW-1:0] r);
    logic [RadixW-1:0] e;
    if (r < RadixMin) begin
      e = RadixMin;
    end else if (r > RadixMax) begin
      e = RadixMax;
    end else begin
      e = r;
    end
    return e;
  endfunction

  function automatic logic [CharW-1:0] digit_char(input logic [RadixW-1:0] d);
    logic [RadixW-1:0] dm;
    logic [CharW-1:0] c;
    dm = (d >= RadixMax) ? RadixW'(d - RadixMax) : d;
    if (dm < RadixDecimal) begin
      c = CharW'(CharZero + {2'b00, dm});
    end else begin
      c = CharW'(CharLetterA + {2'b00, dm} - CharW'(RadixDecimal));
    end
    return c;
  endfunction

endpackage

// ----- rtl/i2a_useq.sv -----
module i2a_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  i2a_pkg::status_t status_i,
  output i2a_pkg::ctrl_t   ctrl_o,
  output logic             busy_o
);

  logic [i2a_pkg::PcW-1:0] pc_q, pc_d;
  logic                    take;

  assign ctrl_o = i2a_pkg::rom_word(pc_q);
  assign busy_o = (pc_q != i2a_pkg::PcIdle);

  always_comb begin
    case (ctrl_o.cond)
      i2a_pkg::CondNever:      take = 1'b0;
      i2a_pkg::CondAlways:     take = 1'b1;
      i2a_pkg::CondIdle:       take = !status_i.accept;
      i2a_pkg::CondDivMore:    take = status_i.div_more;
      i2a_pkg::CondMoreDigits: take = status_i.more_digits;
      i2a_pkg::CondMoreChars:  take = status_i.more_chars;
      default:                 take = 1'b1;
    endcase
    pc_d = take ? ctrl_o.target : i2a_pkg::PcW'(pc_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= i2a_pkg::PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- rtl/integer_to_radix_ascii.sv -----
// Conversion: each digit is the remainder of dividing the magnitude by the radix, found
//   one divide bit per cycle; a leading minus is emitted before the digits.
// Flow: a new number is accepted only while idle; each character is read back from the
//   digit store, then emitted. Results come one per strobe, no stall.
// Reset: rst_ni async, active low; radix returns to 10, sequencer goes idle.
module integer_to_radix_ascii #(
  parameter int ValueWidth = i2a_pkg::ValueWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [i2a_pkg::RadixW-1:0]      cfg_wdata_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [ValueWidth-1:0]    value_i,
  output logic                            strobe_o,
  output logic [i2a_pkg::CharW-1:0]       character_o,
  output logic                            last_o
);

  localparam int AddrW = $clog2(ValueWidth);
  localparam int CntW  = $clog2(ValueWidth + 1);
  localparam int BitW  = $clog2(ValueWidth);
  localparam int RW    = i2a_pkg::RadixW;
  localparam logic [BitW-1:0] BitLast = BitW'(ValueWidth - 1);

  i2a_pkg::ctrl_t   ctrl;
  i2a_pkg::status_t status;
  logic             busy;

  logic [RW-1:0]         radix_q;
  logic [RW-1:0]         base_q;
  logic                  minus_q;
  logic [ValueWidth-1:0] mag_q, mag_d;
  logic [RW-1:0]         rem_q, rem_d;
  logic [BitW-1:0]       bit_q, bit_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [RW-1:0]         mem [ValueWidth];
  logic [RW-1:0]         rd_q;

  logic                  accept;
  logic [ValueWidth-1:0] v;
  logic [RW-1:0]         eff;
  logic                  minus_ld;
  logic [RW:0]           rem_sh;
  logic [RW:0]           rem_sub;
  logic                  ge;

  i2a_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  assign busy_o   = busy;
  assign accept   = start_i && !busy;
  assign v        = value_i;
  assign eff      = i2a_pkg::effective_radix(radix_q);
  assign minus_ld = v[ValueWidth-1] && (eff == i2a_pkg::RadixDecimal);

  assign rem_sh  = {rem_q, mag_q[ValueWidth-1]};
  assign ge      = (rem_sh >= {1'b0, base_q});
  assign rem_sub = rem_sh - {1'b0, base_q};

  assign status.accept      = accept;
  assign status.div_more    = (bit_q != BitLast);
  assign status.more_digits = (mag_q != '0) && (cnt_q < CntW'(ValueWidth - 1));
  assign status.more_chars  = (cnt_q != CntW'(1));

  always_comb begin
    mag_d = mag_q;
    rem_d = rem_q;
    bit_d = bit_q;
    cnt_d = cnt_q;
    case (ctrl.op)
      i2a_pkg::OpWait: begin
        if (accept) begin
          mag_d = minus_ld ? ValueWidth'(~v + 1'b1) : v;
          rem_d = '0;
          bit_d = '0;
          cnt_d = '0;
        end
      end
      i2a_pkg::OpDiv: begin
        mag_d = {mag_q[ValueWidth-2:0], ge};
        rem_d = ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
        bit_d = BitW'(bit_q + 1'b1);
      end
      i2a_pkg::OpStore: begin
        rem_d = '0;
        bit_d = '0;
        cnt_d = CntW'(cnt_q + 1'b1);
      end
      i2a_pkg::OpEmit: begin
        cnt_d = CntW'(cnt_q - 1'b1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= i2a_pkg::RadixReset;
      base_q   <= i2a_pkg::RadixDecimal;
      minus_q  <= 1'b0;
      mag_q    <= '0;
      rem_q    <= '0;
      bit_q    <= '0;
      cnt_q    <= '0;
      strobe_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (accept) begin
        base_q  <= eff;
        minus_q <= minus_ld;
      end
      mag_q    <= mag_d;
      rem_q    <= rem_d;
      bit_q    <= bit_d;
      cnt_q    <= cnt_d;
      strobe_o <= (ctrl.op == i2a_pkg::OpEmit) || ((ctrl.op == i2a_pkg::OpSign) && minus_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.op == i2a_pkg::OpStore) begin
      mem[cnt_q[AddrW-1:0]] <= rem_q;
    end
    if (ctrl.op == i2a_pkg::OpRead) begin
      rd_q <= mem[AddrW'(cnt_q - 1'b1)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.op == i2a_pkg::OpSign) begin
      character_o <= i2a_pkg::CharMinus;
      last_o      <= 1'b0;
    end else if (ctrl.op == i2a_pkg::OpEmit) begin
      character_o <= i2a_pkg::digit_char(rd_q);
      last_o      <= (cnt_q == CntW'(1));
    end
  end

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("strobe follows a last character");

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy_o)
    else $error("result strobe while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted beat did not start conversion");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ValueWidth))
    else $error("digit count out of range");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int ValueW = 32;
  localparam int CycleLimit = 1000000;
  localparam int TailCycles = 64;
  localparam int RandomItems = 140;

  typedef struct packed {
    logic [i2a_pkg::CharW-1:0] code;
    logic                      last;
  } text_char_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [i2a_pkg::RadixW-1:0]   cfg_wdata_i = '0;
  logic                         start_i = 1'b0;
  logic signed [ValueW-1:0]     value_i = '0;
  logic                         busy_o;
  logic                         strobe_o;
  logic [i2a_pkg::CharW-1:0]    character_o;
  logic                         last_o;

  logic [i2a_pkg::RadixW-1:0] radix_setting = i2a_pkg::RadixReset;
  text_char_t        pending_chars[$];
  int                mismatch_count = 0;
  int                cycle_count = 0;
  int                numbers_sent = 0;
  int                chars_checked = 0;
  int                radix_writes = 0;

  integer_to_radix_ascii #(.ValueWidth(ValueW)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .value_i    (value_i),
    .strobe_o   (strobe_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d chars still expected", cycle_count,
               pending_chars.size());
      $display("FAIL integer_to_radix_ascii");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // expected text of one number under the current radix setting
  function automatic void predict_text(input logic [ValueW-1:0] v);
    logic [i2a_pkg::RadixW-1:0] base;
    logic [ValueW-1:0]          mag;
    logic [i2a_pkg::RadixW-1:0] digits[ValueW];
    logic [i2a_pkg::RadixW-1:0] d;
    logic                       minus;
    text_char_t                 tc;
    int                         n;
    base = radix_setting;
    if (base < i2a_pkg::RadixMin) begin
      base = i2a_pkg::RadixMin;
    end else if (base > i2a_pkg::RadixMax) begin
      base = i2a_pkg::RadixMax;
    end
    minus = (base == i2a_pkg::RadixDecimal) && v[ValueW-1];
    mag = minus ? -v : v;
    n = 0;
    do begin
      digits[n] = i2a_pkg::RadixW'(mag % base);
      n++;
      mag = mag / base;
    end while (mag != 0 && n < ValueW);
    if (minus) begin
      tc.code = i2a_pkg::CharMinus;
      tc.last = 1'b0;
      pending_chars.push_back(tc);
    end
    for (int k = n - 1; k >= 0; k--) begin
      d = digits[k];
      tc.code = (d < i2a_pkg::RadixDecimal)
              ? i2a_pkg::CharW'(i2a_pkg::CharZero + d)
              : i2a_pkg::CharW'(i2a_pkg::CharLetterA + d - i2a_pkg::RadixDecimal);
      tc.last = (k == 0);
      pending_chars.push_back(tc);
    end
  endfunction

  // each character beat is checked against the oldest expectation
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && strobe_o) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b", character_o, last_o));
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (character_o !== want.code) begin
          report_mismatch($sformatf("char %h, want %h", character_o, want.code));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("last %b, want %b (char %h)", last_o, want.last,
                                    want.code));
        end
      end
    end
  end

  task automatic send_value(input logic [ValueW-1:0] v, input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    predict_text(v);
    numbers_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_chars.size() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic write_radix(input logic [i2a_pkg::RadixW-1:0] r);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    radix_setting = r;
    radix_writes++;
  endtask

  function automatic logic [ValueW-1:0] random_value();
    logic [ValueW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = ValueW'($urandom_range(0, 40));
      1: v = -ValueW'($urandom_range(1, 40));
      2: v = {1'($urandom_range(0, 1)), {(ValueW-1){1'b0}}} | ValueW'($urandom_range(0, 3));
      3: v = ValueW'($urandom) >> $urandom_range(0, ValueW - 1);
      default: v = ValueW'($urandom);
    endcase
    return v;
  endfunction

  task automatic test_decimal_after_reset();
    send_value(32'd0, $urandom_range(0, 15));
    send_value(32'd1, $urandom_range(0, 15));
    send_value(-32'sd1, $urandom_range(0, 15));
    send_value(32'h7FFF_FFFF, 0);
    send_value(32'h8000_0000, $urandom_range(0, 15));
    send_value(32'd1234567890, 0);
    send_value(-32'sd987654321, $urandom_range(0, 15));
  endtask

  task automatic test_radix_extremes();
    write_radix(6'd2);
    send_value(32'd0, 0);
    send_value(32'hFFFF_FFFF, $urandom_range(0, 15));
    send_value(32'h8000_0000, 0);
    write_radix(6'd16);
    send_value(32'hDEAD_BEEF, $urandom_range(0, 15));
    send_value(32'h7FFF_FFFF, 0);
    write_radix(6'd36);
    send_value(32'hFFFF_FFFF, 0);
    send_value(32'd35, $urandom_range(0, 15));
    write_radix(6'd0);
    send_value(32'd5, 0);
    write_radix(6'd1);
    send_value(-32'sd6, 0);
    write_radix(6'd37);
    send_value(32'd1295, 0);
    write_radix(6'd63);
    send_value(-32'sd10, 0);
    write_radix(6'd8);
    send_value(32'h8000_0000, 0);
  endtask

  task automatic test_random_phases();
    int sent;
    int phase_len;
    int pause_at;
    bit burst;
    sent = 0;
    while (sent < RandomItems) begin
      write_radix(($urandom_range(0, 3) == 0) ? i2a_pkg::RadixW'($urandom_range(0, 63))
                                              : i2a_pkg::RadixW'($urandom_range(2, 36)));
      phase_len = $urandom_range(8, 20);
      pause_at = $urandom_range(1, phase_len - 1);
      burst = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < phase_len; i++) begin
        if (i == pause_at) begin
          wait_drained();
        end
        send_value(random_value(), burst ? 0 : $urandom_range(0, 15));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_decimal_after_reset();
    test_radix_extremes();
    test_random_phases();
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    $display("converted %0d numbers into %0d checked chars over %0d radix writes",
             numbers_sent, chars_checked, radix_writes);
    $display("mismatches: %0d, cycles: %0d", mismatch_count, cycle_count);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("PASS integer_to_radix_ascii");
    end else begin
      $display("FAIL integer_to_radix_ascii");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/i2a_pkg.sv
rtl/i2a_useq.sv
rtl/integer_to_radix_ascii.sv
tb/testbench.sv
